/* rtl/cllp_pkg.sv */
`timescale 1ns / 1ps

package cllp_pkg;

    localparam int MAX_BYTES_DEF     = 8;
    localparam int CHANNEL_CHARS_DEF = 15;
    localparam logic [63:0] US_PER_S = 64'd1000000;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_CHANNEL = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_line;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        ok;
        logic [63:0] timestamp_us;
        logic [31:0] can_id;
        logic [3:0]  channel_length;
        logic [3:0]  byte_count;
        logic [7:0]  element;
        logic [3:0]  element_index;
        logic        last;
    } out_word_t;

endpackage

/* rtl/cllp_if.sv */
`timescale 1ns / 1ps

interface cllp_in_if;
    logic              valid;
    logic              ready;
    cllp_pkg::in_word_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cllp_out_if;
    logic               valid;
    logic               ready;
    cllp_pkg::out_word_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/cllp_cell.sv */
`timescale 1ns / 1ps

// One byte of a store chain: loads in place, shifts toward cell 0 on drain.
module cllp_cell
(
    input  logic       clk,
    input  logic       load,
    input  logic [7:0] load_data,
    input  logic       shift,
    input  logic [7:0] neighbor,
    output logic [7:0] q
);

    logic [7:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
        else if (shift)
        begin
            data_reg <= neighbor;
        end
    end

    assign q = data_reg;

endmodule

/* rtl/can_log_line_parser.sv */
`timescale 1ns / 1ps
// CAN log line parser, "(sec.usec) channel hexid#payload", one character per word.
// Throughput: one character word per cycle while no run is being emitted; the accumulators are updated in place.
// An end word is followed in the next cycle by the header word; the run of
// 1 + channels + bytes words then leaves at one per cycle while ready is high, input held off meanwhile.
// Reset (rst_n low, asynchronous): parser at opening parenthesis, output empty.
module can_log_line_parser
#(
    parameter int MAX_BYTES     = cllp_pkg::MAX_BYTES_DEF,
    parameter int CHANNEL_CHARS = cllp_pkg::CHANNEL_CHARS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    cllp_in_if.sink    line,
    cllp_out_if.source result
);

    localparam int CW = $clog2(CHANNEL_CHARS + 1);
    localparam int BW = $clog2(MAX_BYTES + 1);
    localparam int IW = (CW > BW) ? CW : BW;

    // Parse phases; order matters, everything below PAYLOAD fails at string end.
    typedef enum logic [3:0] {
        PH_OPEN, PH_SEC, PH_USEC, PH_PRE_CHAN, PH_CHAN,
        PH_PRE_ID, PH_ID, PH_PAYLOAD, PH_DRAIN
    } phase_t;

    typedef enum logic {
        ST_PARSE, ST_EMIT
    } state_t;

    phase_t      phase_reg, phase_next;
    state_t      state_reg, state_next;
    logic [63:0] sec_scaled_reg, sec_scaled_next;   // seconds times 1e6, built per digit
    logic [63:0] micros_reg, micros_next;
    logic [63:0] time_reg, time_next;
    logic [31:0] id_reg, id_next;
    logic [CW-1:0] chan_cnt_reg, chan_cnt_next;
    logic [BW-1:0] pay_cnt_reg, pay_cnt_next;
    logic [3:0]  nib_reg, nib_next;
    logic        pend_reg, pend_next;
    logic        failed_reg, failed_next;
    logic [CW-1:0] chan_left_reg, chan_left_next;
    logic [BW-1:0] pay_left_reg, pay_left_next;
    logic [IW-1:0] idx_reg, idx_next;
    cllp_pkg::out_word_t out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic        chan_store, pay_store, chan_shift, pay_shift;
    logic [7:0]  pay_byte;
    logic [7:0]  chan_q [CHANNEL_CHARS];
    logic [7:0]  pay_q  [MAX_BYTES];

    logic [7:0]  c;
    logic [3:0]  hv;
    logic        is_hex, is_dig, is_blank, take, line_bad;

    always_comb
    begin
        c        = line.payload.character;
        is_dig   = (c >= 8'h30) && (c <= 8'h39);
        is_blank = (c == cllp_pkg::CH_SPACE) || (c == cllp_pkg::CH_TAB);
        is_hex   = 1'b1;
        hv       = 4'd0;
        if (is_dig)
        begin
            hv = c[3:0];
        end
        else if (((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66)))
        begin
            hv = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    assign take     = line.valid && line.ready;
    assign line_bad = failed_reg || (phase_reg < PH_PAYLOAD);

    always_comb
    begin
        phase_next      = phase_reg;
        state_next      = state_reg;
        sec_scaled_next = sec_scaled_reg;
        micros_next     = micros_reg;
        time_next       = time_reg;
        id_next         = id_reg;
        chan_cnt_next   = chan_cnt_reg;
        pay_cnt_next    = pay_cnt_reg;
        nib_next        = nib_reg;
        pend_next       = pend_reg;
        failed_next     = failed_reg;
        chan_left_next  = chan_left_reg;
        pay_left_next   = pay_left_reg;
        idx_next        = idx_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        chan_store      = 1'b0;
        pay_store       = 1'b0;
        chan_shift      = 1'b0;
        pay_shift       = 1'b0;
        pay_byte        = {nib_reg, hv};

        if (take && line.payload.end_of_line)
        begin
            // header out, line state back to reset
            out_next                = '0;
            out_next.kind           = cllp_pkg::KIND_HEADER;
            out_next.ok             = !line_bad;
            out_valid_next          = 1'b1;
            if (line_bad)
            begin
                out_next.last  = 1'b1;
                chan_left_next = '0;
                pay_left_next  = '0;
            end
            else
            begin
                out_next.timestamp_us   = time_reg;
                out_next.can_id         = id_reg;
                out_next.channel_length = 4'(chan_cnt_reg);
                out_next.byte_count     = 4'(pay_cnt_reg);
                out_next.last           = (chan_cnt_reg == '0) && (pay_cnt_reg == '0);
                chan_left_next          = chan_cnt_reg;
                pay_left_next           = pay_cnt_reg;
            end
            idx_next        = '0;
            state_next      = ST_EMIT;
            phase_next      = PH_OPEN;
            sec_scaled_next = '0;
            micros_next     = '0;
            time_next       = '0;
            id_next         = '0;
            chan_cnt_next   = '0;
            pay_cnt_next    = '0;
            nib_next        = '0;
            pend_next       = 1'b0;
            failed_next     = 1'b0;
        end
        else if (take && (phase_reg != PH_DRAIN))
        begin
            if (c == cllp_pkg::CH_NUL)
            begin
                if (phase_reg < PH_PAYLOAD)
                begin
                    failed_next = 1'b1;
                end
                phase_next = PH_DRAIN;
            end
            else
            begin
                unique case (phase_reg)
                    PH_OPEN:
                    begin
                        if (c == cllp_pkg::CH_OPEN) phase_next = PH_SEC;
                        else begin failed_next = 1'b1; phase_next = PH_DRAIN; end
                    end
                    PH_SEC:
                    begin
                        if (is_dig)
                            sec_scaled_next = (sec_scaled_reg << 3) + (sec_scaled_reg << 1)
                                              + 64'(c[3:0]) * cllp_pkg::US_PER_S;
                        else if (c == cllp_pkg::CH_DOT) phase_next = PH_USEC;
                        else begin failed_next = 1'b1; phase_next = PH_DRAIN; end
                    end
                    PH_USEC:
                    begin
                        if (is_dig)
                            micros_next = (micros_reg << 3) + (micros_reg << 1) + 64'(c[3:0]);
                        else if (c == cllp_pkg::CH_CLOSE)
                        begin
                            time_next  = sec_scaled_reg + micros_reg;
                            phase_next = PH_PRE_CHAN;
                        end
                        else begin failed_next = 1'b1; phase_next = PH_DRAIN; end
                    end
                    PH_PRE_CHAN, PH_CHAN:
                    begin
                        if (is_blank)
                        begin
                            if (phase_reg == PH_CHAN) phase_next = PH_PRE_ID;
                        end
                        else
                        begin
                            chan_store    = 1'b1;
                            chan_cnt_next = chan_cnt_reg + 1'b1;
                            phase_next    = (chan_cnt_next == CW'(CHANNEL_CHARS))
                                            ? PH_PRE_ID : PH_CHAN;
                        end
                    end
                    PH_PRE_ID, PH_ID:
                    begin
                        if (c == cllp_pkg::CH_HASH) phase_next = PH_PAYLOAD;
                        else if ((phase_reg == PH_PRE_ID) && is_blank) phase_next = phase_reg;
                        else if (is_hex)
                        begin
                            id_next    = {id_reg[27:0], hv};
                            phase_next = PH_ID;
                        end
                        else begin failed_next = 1'b1; phase_next = PH_DRAIN; end
                    end
                    PH_PAYLOAD:
                    begin
                        if (!pend_reg)
                        begin
                            if (is_hex)
                            begin
                                nib_next  = hv;
                                pend_next = 1'b1;
                            end
                            else if (!is_blank) phase_next = PH_DRAIN;
                        end
                        else
                        begin
                            pend_next = 1'b0;
                            if (is_hex)
                            begin
                                pay_store    = 1'b1;
                                pay_cnt_next = pay_cnt_reg + 1'b1;
                                if (pay_cnt_next == BW'(MAX_BYTES)) phase_next = PH_DRAIN;
                            end
                            else phase_next = PH_DRAIN;
                        end
                    end
                    default: phase_next = phase_reg;
                endcase
            end
        end

        // drain the run from the heads of the two chains
        if ((state_reg == ST_EMIT) && out_valid_reg && result.ready)
        begin
            out_next = '0;
            if (chan_left_reg != '0)
            begin
                out_next.kind          = cllp_pkg::KIND_CHANNEL;
                out_next.element       = chan_q[0];
                out_next.element_index = 4'(idx_reg);
                out_next.last          = (pay_left_reg == '0) && (chan_left_reg == CW'(1));
                chan_shift             = 1'b1;
                chan_left_next         = chan_left_reg - 1'b1;
                idx_next               = (chan_left_reg == CW'(1)) ? '0 : idx_reg + 1'b1;
            end
            else if (pay_left_reg != '0)
            begin
                out_next.kind          = cllp_pkg::KIND_PAYLOAD;
                out_next.element       = pay_q[0];
                out_next.element_index = 4'(idx_reg);
                out_next.last          = (pay_left_reg == BW'(1));
                pay_shift              = 1'b1;
                pay_left_next          = pay_left_reg - 1'b1;
                idx_next               = idx_reg + 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
                state_next     = ST_PARSE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_OPEN;
            state_reg      <= ST_PARSE;
            sec_scaled_reg <= '0;
            micros_reg     <= '0;
            time_reg       <= '0;
            id_reg         <= '0;
            chan_cnt_reg   <= '0;
            pay_cnt_reg    <= '0;
            nib_reg        <= '0;
            pend_reg       <= 1'b0;
            failed_reg     <= 1'b0;
            chan_left_reg  <= '0;
            pay_left_reg   <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            state_reg      <= state_next;
            sec_scaled_reg <= sec_scaled_next;
            micros_reg     <= micros_next;
            time_reg       <= time_next;
            id_reg         <= id_next;
            chan_cnt_reg   <= chan_cnt_next;
            pay_cnt_reg    <= pay_cnt_next;
            nib_reg        <= nib_next;
            pend_reg       <= pend_next;
            failed_reg     <= failed_next;
            chan_left_reg  <= chan_left_next;
            pay_left_reg   <= pay_left_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // channel chain: cell i loads the i-th character, drain shifts toward cell 0
    for (genvar i = 0; i < CHANNEL_CHARS; i++)
    begin : g_chan
        logic [7:0] nb;
        if (i == CHANNEL_CHARS - 1)
        begin : g_end
            assign nb = 8'h00;
        end
        else
        begin : g_mid
            assign nb = chan_q[i+1];
        end
        cllp_cell u_cell
        (
            .clk       (clk),
            .load      (chan_store && (chan_cnt_reg == CW'(i))),
            .load_data (c),
            .shift     (chan_shift),
            .neighbor  (nb),
            .q         (chan_q[i])
        );
    end

    // payload chain, same scheme
    for (genvar i = 0; i < MAX_BYTES; i++)
    begin : g_pay
        logic [7:0] nb;
        if (i == MAX_BYTES - 1)
        begin : g_end
            assign nb = 8'h00;
        end
        else
        begin : g_mid
            assign nb = pay_q[i+1];
        end
        cllp_cell u_cell
        (
            .clk       (clk),
            .load      (pay_store && (pay_cnt_reg == BW'(i))),
            .load_data (pay_byte),
            .shift     (pay_shift),
            .neighbor  (nb),
            .q         (pay_q[i])
        );
    end

    assign line.ready     = (state_reg == ST_PARSE);
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !line.ready)
        else $error("input taken while a run is pending");

    a_header_first: assert property (@(posedge clk) disable iff (!rst_n)
        (line.valid && line.ready && line.payload.end_of_line) |=>
        (result.valid && (result.payload.kind == cllp_pkg::KIND_HEADER)))
        else $error("run does not open with a header");

    a_bad_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.payload.kind == cllp_pkg::KIND_HEADER)
         && !result.payload.ok) |-> result.payload.last)
        else $error("failed line emits more than a header");
`endif

endmodule

/* tb/tb_can_log_line_parser.sv */
`timescale 1ns / 1ps

module tb;

    localparam int MAX_CH      = 15;
    localparam int MAX_PL      = 8;
    localparam int WDOG_LIMIT  = 20000;
    localparam int N_RANDOM    = 90;

    // parser phases of the line predictor
    typedef enum int {
        P_OPEN, P_SEC, P_USEC, P_PRE_CHAN, P_CHAN, P_PRE_ID, P_ID, P_PAYLOAD, P_DRAIN
    } pred_phase_t;

    // Line predictor plus queue of expected run words.
    class run_scoreboard;
        pred_phase_t phase;
        logic [63:0] sec_acc, usec_acc, stamp;
        logic [31:0] id_acc;
        logic [7:0]  chan[MAX_CH];
        int          chan_n;
        logic [7:0]  bytes[MAX_PL];
        int          byte_n;
        logic [3:0]  hi_nib;
        bit          nib_pend;
        bit          failed;
        cllp_pkg::out_word_t pending_runs[$];
        int          mismatches;

        function new();
            mismatches = 0;
            clear_line();
        endfunction

        function void clear_line();
            phase = P_OPEN;
            sec_acc = '0; usec_acc = '0; stamp = '0; id_acc = '0;
            chan_n = 0; byte_n = 0; hi_nib = '0; nib_pend = 0; failed = 0;
        endfunction

        function bit blank(logic [7:0] c);
            return c == cllp_pkg::CH_SPACE || c == cllp_pkg::CH_TAB;
        endfunction

        function int hexval(logic [7:0] c);
            if (c >= "0" && c <= "9") return c - "0";
            if (c >= "A" && c <= "F") return c - "A" + 10;
            if (c >= "a" && c <= "f") return c - "a" + 10;
            return -1;
        endfunction

        function void fail_it();
            failed = 1;
            phase = P_DRAIN;
        endfunction

        function void take_char(logic [7:0] c);
            int v;
            v = hexval(c);
            case (phase)
                P_OPEN: if (c == cllp_pkg::CH_OPEN) phase = P_SEC; else fail_it();
                P_SEC:
                    if (c >= "0" && c <= "9") sec_acc = sec_acc * 10 + 64'(c - "0");
                    else if (c == cllp_pkg::CH_DOT) phase = P_USEC;
                    else fail_it();
                P_USEC:
                    if (c >= "0" && c <= "9") usec_acc = usec_acc * 10 + 64'(c - "0");
                    else if (c == cllp_pkg::CH_CLOSE) begin
                        stamp = sec_acc * cllp_pkg::US_PER_S + usec_acc;
                        phase = P_PRE_CHAN;
                    end
                    else fail_it();
                P_PRE_CHAN, P_CHAN:
                    if (blank(c)) begin
                        if (phase == P_CHAN) phase = P_PRE_ID;
                    end
                    else begin
                        if (chan_n < MAX_CH) begin
                            chan[chan_n] = c;
                            chan_n++;
                        end
                        phase = (chan_n >= MAX_CH) ? P_PRE_ID : P_CHAN;
                    end
                P_PRE_ID, P_ID:
                    if (c == cllp_pkg::CH_HASH) phase = P_PAYLOAD;
                    else if (phase == P_PRE_ID && blank(c)) ;
                    else if (v >= 0) begin
                        id_acc = {id_acc[27:0], 4'(v)};
                        phase = P_ID;
                    end
                    else fail_it();
                P_PAYLOAD:
                    if (byte_n >= MAX_PL) phase = P_DRAIN;
                    else if (!nib_pend) begin
                        if (!blank(c)) begin
                            if (v >= 0) begin
                                hi_nib = 4'(v);
                                nib_pend = 1;
                            end
                            else phase = P_DRAIN;
                        end
                    end
                    else begin
                        nib_pend = 0;
                        if (v >= 0) begin
                            bytes[byte_n] = {hi_nib, 4'(v)};
                            byte_n++;
                            if (byte_n >= MAX_PL) phase = P_DRAIN;
                        end
                        else phase = P_DRAIN;
                    end
                default: ;
            endcase
        endfunction

        // note one accepted input word
        function void note_input(cllp_pkg::in_word_t w);
            cllp_pkg::out_word_t o;
            if (!w.end_of_line) begin
                if (phase == P_DRAIN) return;
                if (w.character == cllp_pkg::CH_NUL) begin
                    if (phase < P_PAYLOAD) failed = 1;
                    phase = P_DRAIN;
                end
                else take_char(w.character);
                return;
            end
            if (phase < P_PAYLOAD) failed = 1;
            o = '0;
            o.kind = cllp_pkg::KIND_HEADER;
            if (failed) begin
                o.last = 1;
                pending_runs.push_back(o);
            end
            else begin
                o.ok = 1;
                o.timestamp_us = stamp;
                o.can_id = id_acc;
                o.channel_length = 4'(chan_n);
                o.byte_count = 4'(byte_n);
                o.last = (chan_n + byte_n) == 0;
                pending_runs.push_back(o);
                for (int i = 0; i < chan_n; i++) begin
                    o = '0;
                    o.kind = cllp_pkg::KIND_CHANNEL;
                    o.element = chan[i];
                    o.element_index = 4'(i);
                    o.last = byte_n == 0 && i + 1 == chan_n;
                    pending_runs.push_back(o);
                end
                for (int i = 0; i < byte_n; i++) begin
                    o = '0;
                    o.kind = cllp_pkg::KIND_PAYLOAD;
                    o.element = bytes[i];
                    o.element_index = 4'(i);
                    o.last = i + 1 == byte_n;
                    pending_runs.push_back(o);
                end
            end
            clear_line();
        endfunction

        // compare one accepted output word against the oldest expected one
        function void check_result(cllp_pkg::out_word_t got);
            cllp_pkg::out_word_t want;
            if (pending_runs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
                return;
            end
            want = pending_runs.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp kind=%0d ok=%0d ts=%h id=%h cl=%0d bc=%0d",
                        want.kind, want.ok, want.timestamp_us, want.can_id,
                        want.channel_length, want.byte_count);
                    $display("          exp el=%h ei=%0d last=%0d",
                        want.element, want.element_index, want.last);
                    $display("          got kind=%0d ok=%0d ts=%h id=%h cl=%0d bc=%0d",
                        got.kind, got.ok, got.timestamp_us, got.can_id,
                        got.channel_length, got.byte_count);
                    $display("          got el=%h ei=%0d last=%0d",
                        got.element, got.element_index, got.last);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    cllp_in_if  line_ch();
    cllp_out_if result_ch();

    can_log_line_parser DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .line   (line_ch.sink),
        .result (result_ch.source)
    );

    run_scoreboard sb;
    int  idle_cycles = 0;
    bit  hold_sink = 0;   // long receiver hold-off request
    cllp_pkg::in_word_t text_q[$];  // words staged for the sender

    initial clk = 0;
    always #10 clk = ~clk;

    // short gap most of the time, occasionally a long one
    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // scoreboard hooks on accepted words
    always @(posedge clk) begin
        if (rst_n && line_ch.valid && line_ch.ready) sb.note_input(line_ch.payload);
        if (rst_n && result_ch.valid && result_ch.ready) sb.check_result(result_ch.payload);
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge clk) begin
        if ((line_ch.valid && line_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("can_log_line_parser test failed");
            $finish;
        end
    end

    // receiver: random ready, plus one long hold-off on request
    initial begin
        int g;
        bit held;
        held = 0;
        result_ch.ready = 0;
        @(posedge rst_n);
        forever begin
            if (hold_sink && !held) begin
                result_ch.ready <= 0;
                repeat (60) @(posedge clk);
                held = 1;
            end
            g = ($urandom_range(0, 4) == 0) ? gap_len() : 0;
            if (g > 0) begin
                result_ch.ready <= 0;
                repeat (g) @(posedge clk);
            end
            result_ch.ready <= 1;
            @(posedge clk);
        end
    end

    // staging helpers
    task automatic put_char(logic [7:0] c);
        cllp_pkg::in_word_t w;
        w.character = c;
        w.end_of_line = 0;
        text_q.push_back(w);
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endtask

    task automatic put_end(logic [7:0] junk = 8'h00);
        cllp_pkg::in_word_t w;
        w.character = junk;
        w.end_of_line = 1;
        text_q.push_back(w);
    endtask

    function automatic logic [7:0] hex_digit(int v, bit upper);
        if (v < 10) return 8'("0" + v);
        return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")
               || c == cllp_pkg::CH_HASH);
        return c;
    endfunction

    // one well-formed line with random content, sometimes lightly broken
    task automatic put_random_line();
        int n;
        int brk;
        brk = $urandom_range(0, 9);
        put_char(cllp_pkg::CH_OPEN);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 4);
        repeat (n) put_char(8'("0" + $urandom_range(0, 9)));
        put_char(cllp_pkg::CH_DOT);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 6);
        repeat (n) put_char(8'("0" + $urandom_range(0, 9)));
        if (brk == 0) put_char(rand_non_hex());
        put_char(cllp_pkg::CH_CLOSE);
        repeat ($urandom_range(0, 2))
            put_char($urandom_range(0, 1) ? cllp_pkg::CH_SPACE : cllp_pkg::CH_TAB);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 5);
        repeat (n) put_char(8'($urandom_range(33, 255)) == cllp_pkg::CH_HASH ? "x"
                            : 8'($urandom_range(33, 255)));
        repeat ($urandom_range(1, 2)) put_char(cllp_pkg::CH_SPACE);
        n = $urandom_range(0, 10);
        repeat (n) put_char(hex_digit($urandom_range(0, 15), $urandom_range(0, 1)));
        if (brk == 1) put_char(rand_non_hex());
        if (brk == 2) put_char(cllp_pkg::CH_NUL);
        put_char(cllp_pkg::CH_HASH);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) put_char(cllp_pkg::CH_SPACE);
            put_char(hex_digit($urandom_range(0, 15), $urandom_range(0, 1)));
            put_char(hex_digit($urandom_range(0, 15), $urandom_range(0, 1)));
        end
        case (brk)
            3: put_char(8'h0A);
            4: begin put_char("a"); put_char(cllp_pkg::CH_SPACE); put_text("bc"); end
            5: put_char(cllp_pkg::CH_NUL);
            default: ;
        endcase
        repeat ($urandom_range(0, 2)) put_char(8'($urandom_range(0, 255)));
        put_end(8'($urandom_range(0, 255)));
    endtask

    // sender: plays out the staged words with random gaps
    task automatic send_all();
        int g;
        while (text_q.size() > 0) begin
            g = gap_len();
            if (g > 0) begin
                line_ch.valid <= 0;
                repeat (g) @(posedge clk);
            end
            line_ch.valid   <= 1;
            line_ch.payload <= text_q.pop_front();
            do @(posedge clk); while (!line_ch.ready);
        end
        line_ch.valid <= 0;
    endtask

    initial begin
        int sent;
        sb = new();
        rst_n = 0;
        line_ch.valid = 0;
        line_ch.payload = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed lines: full-width fields, overlong channel, max payload,
        // malformed prefixes, terminator and blank-split pairs
        put_text("(18446744073709551615.999999) can0 FFFFFFFF#0011223344556677");
        put_end();
        put_text("(1.2) ABCDEFGHIJKLMNOPQ 123456789#aaBBccDDeeFF0099AA");
        put_end();
        put_text("(0.0) \xff\x80 7#");
        put_end();
        put_text("(5.5) c 1 2#11");
        put_end();
        put_text("x(1.2) c 1#11");
        put_end();
        put_text("(1a.2) c 1#11");
        put_end();
        put_text("(1.2] c 1#11");
        put_end();
        put_text("(1.2) c 1");
        put_char(cllp_pkg::CH_NUL);
        put_text("#11");
        put_end();
        put_end();
        put_text("(3.4)\tc\t0#12 34 5 67");
        put_char(cllp_pkg::CH_NUL);
        put_text("89");
        put_end();
        put_text("(3.4) c 0#1\n");
        put_end();
        send_all();

        // pressure: receiver holds off while a long line is offered
        hold_sink = 1;
        put_text("(9.9) ABCDEFGHIJKLMNO 1#0102030405060708");
        put_end();
        put_text("(9.9) x 1#aa");
        put_end();
        send_all();

        sent = 0;
        while (sent < N_RANDOM) begin
            if ($urandom_range(0, 15) == 0) begin
                repeat ($urandom_range(1, 6)) put_char(8'($urandom_range(0, 255)));
                put_end();
            end
            else put_random_line();
            sent += text_q.size();
            send_all();
        end

        while (sb.pending_runs.size() > 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0)
            $display("can_log_line_parser test passed");
        else
            $display("can_log_line_parser test failed");
        $finish;
    end
endmodule
